### rtl/core/wildcard_glob_matcher_defines.svh
// Assertion macros for the wildcard glob matcher checker.
// Included by wgm_checker.sv; needs no package.
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

// property checked on every edge outside reset
`define WGM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define WGM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/wgm_pkg.sv
// Shared types and constants for the wildcard glob matcher.
// No dependencies.
`timescale 1ns / 1ps

package wgm_pkg;

  localparam int PAT_SLOTS = 32;
  localparam int LEN_W     = 6;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;

  localparam logic [7:0] CHAR_STAR     = 8'h2A;
  localparam logic [7:0] CHAR_QUESTION = 8'h3F;

  typedef enum logic [2:0] {
    REG_WORD0  = 3'd0,
    REG_WORD1  = 3'd1,
    REG_WORD2  = 3'd2,
    REG_WORD3  = 3'd3,
    REG_LENGTH = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [PAT_SLOTS-1:0][7:0] chars;
    logic [LEN_W-1:0]          length;
    logic                      restart;
  } pat_cfg_t;

endpackage

### rtl/core/wgm_cfg.sv
// APB register file holding the pattern words and the pattern length.
// Depends on wgm_pkg.
`timescale 1ns / 1ps

module wgm_cfg import wgm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output pat_cfg_t          pcfg
);

  logic [3:0][DATA_W-1:0] words;
  logic [LEN_W-1:0]       length;
  logic                   wr_en;
  logic                   wr_hit;
  reg_idx_t               idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    wr_hit = 1'b0;
    prdata = '0;
    unique case (idx)
      REG_WORD0:  begin wr_hit = 1'b1; prdata = words[0]; end
      REG_WORD1:  begin wr_hit = 1'b1; prdata = words[1]; end
      REG_WORD2:  begin wr_hit = 1'b1; prdata = words[2]; end
      REG_WORD3:  begin wr_hit = 1'b1; prdata = words[3]; end
      REG_LENGTH: begin wr_hit = 1'b1; prdata = DATA_W'(length); end
      default:    begin wr_hit = 1'b0; prdata = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words  <= '0;
      length <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_WORD0:  words[0] <= pwdata;
        REG_WORD1:  words[1] <= pwdata;
        REG_WORD2:  words[2] <= pwdata;
        REG_WORD3:  words[3] <= pwdata;
        REG_LENGTH: length   <= pwdata[LEN_W-1:0];
        default:    ;
      endcase
    end
  end

  assign pcfg.chars   = words;
  assign pcfg.length  = length;
  assign pcfg.restart = wr_en && wr_hit;

endmodule

### rtl/core/wgm_step.sv
// Next live-position set for one character, with star closure by prefix scan.
// Depends on wgm_pkg.
`timescale 1ns / 1ps

module wgm_step import wgm_pkg::*; #(
  parameter int PATTERN_MAX = 32
) (
  input  pat_cfg_t               pcfg,
  input  logic [PATTERN_MAX:0]   live_cur,
  input  logic [7:0]             character,
  input  logic                   has_character,
  output logic [PATTERN_MAX:0]   live_next,
  output logic [PATTERN_MAX:0]   start_set,
  output logic                   matched
);

  localparam int W  = PATTERN_MAX + 1;
  localparam int LW = $clog2(PATTERN_MAX + 1);

  logic [LW-1:0]          lenu;
  logic [PATTERN_MAX-1:0] active;
  logic [PATTERN_MAX-1:0] star;
  logic [PATTERN_MAX-1:0] hit;
  logic [W-1:0]           prop;
  logic [W-1:0]           stepped;

  // prefix scan: position j reached from any live k <= j through stars k..j-1
  function automatic logic [W-1:0] closure(input logic [W-1:0] set,
                                           input logic [W-1:0] pr);
    logic [W-1:0] g;
    logic [W-1:0] p;
    g = set;
    p = pr;
    for (int d = 1; d < W; d = d * 2) begin
      g = g | (p & (g << d));
      p = p & (p << d);
    end
    return g;
  endfunction

  always_comb begin
    if (pcfg.length > LEN_W'(PATTERN_MAX)) begin
      lenu = LW'(PATTERN_MAX);
    end else begin
      lenu = pcfg.length[LW-1:0];
    end
    for (int i = 0; i < PATTERN_MAX; i++) begin
      active[i] = (LW'(i) < lenu);
      star[i]   = active[i] && (pcfg.chars[i] == CHAR_STAR);
      hit[i]    = active[i] && live_cur[i] && !star[i] &&
                  ((pcfg.chars[i] == CHAR_QUESTION) || (pcfg.chars[i] == character));
    end
    prop      = {star, 1'b0};
    stepped   = {hit, 1'b0} | {1'b0, live_cur[PATTERN_MAX-1:0] & star};
    start_set = closure(W'(1), prop);
    live_next = has_character ? closure(stepped, prop) : live_cur;
    matched   = live_next[lenu];
  end

endmodule

### rtl/core/wildcard_glob_matcher.sv
// Top level of the wildcard glob matcher: input register, live-set state, result register.
// Depends on wgm_pkg, wgm_cfg and wgm_step.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------
//   in       | in_valid, in_ready  | character, has_character, last
//   out      | out_valid, out_ready| matched
//   config   | APB psel/penable    | paddr, pwdata, prdata (64-bit regs)
//
// One item per cycle unless a last item is held; its result registers as it leaves s1.
// The live set update is one pass through wgm_step, bounded by the star scan.
// Reset clears the pattern and loads the start set; a write to a listed register restarts
// the string.
// A result waiting on out_ready holds only an item carrying last; others keep flowing.
`timescale 1ns / 1ps

module wildcard_glob_matcher import wgm_pkg::*; #(
  parameter int PATTERN_MAX = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        character,
  input  logic              has_character,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              matched
);

  pat_cfg_t             pcfg;
  logic                 s1_valid;
  logic [7:0]           s1_char;
  logic                 s1_has;
  logic                 s1_last;
  logic                 s1_adv;
  logic [PATTERN_MAX:0] live;
  logic                 fresh;
  logic [PATTERN_MAX:0] live_cur;
  logic [PATTERN_MAX:0] live_next;
  logic [PATTERN_MAX:0] start_set;
  logic                 matched_next;

  wgm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pcfg    (pcfg)
  );

  assign live_cur = fresh ? start_set : live;

  wgm_step #(.PATTERN_MAX(PATTERN_MAX)) u_step (
    .pcfg          (pcfg),
    .live_cur      (live_cur),
    .character     (s1_char),
    .has_character (s1_has),
    .live_next     (live_next),
    .start_set     (start_set),
    .matched       (matched_next)
  );

  assign s1_adv   = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fresh     <= 1'b1;
      live      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (in_valid && in_ready) begin
        s1_char <= character;
        s1_has  <= has_character;
        s1_last <= last;
      end
      if (pcfg.restart) begin
        fresh <= 1'b1;
      end else if (s1_adv) begin
        if (s1_last) begin
          fresh <= 1'b1;
        end else if (s1_has) begin
          live  <= live_next;
          fresh <= 1'b0;
        end
      end
      if (s1_adv && s1_last) begin
        out_valid <= 1'b1;
        matched   <= matched_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/wgm_checker.sv
// Port-level assertions for the wildcard glob matcher, bound to the top level.
// Depends on wgm_pkg and wildcard_glob_matcher_defines.svh.
`timescale 1ns / 1ps
`include "wildcard_glob_matcher_defines.svh"

module wgm_checker import wgm_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              matched
);

  `WGM_ASSERT_ALWAYS(a_pready_high, clk, pready, "pready dropped")
  `WGM_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !out_valid, "result left after reset")
  `WGM_ASSERT(a_out_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(matched)), "stalled result changed")
  `WGM_ASSERT(a_length_readback, clk, rst, (psel && penable && pwrite && paddr[5:3] == REG_LENGTH) ##1 (psel && !pwrite && paddr[5:3] == REG_LENGTH) |-> (prdata == DATA_W'($past(pwdata[LEN_W-1:0]))), "length readback wrong")

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
  .clk       (clk),
  .rst       (rst),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .matched   (matched)
);

### tb/wildcard_glob_matcher_test.sv
// Self-checking testbench for the wildcard glob matcher: directed table, then random patterns
// and subject strings under several idling mixes, checked against an in-bench predictor.
// Depends on wgm_pkg and the wildcard_glob_matcher top level.
`timescale 1ns / 1ps

module wildcard_glob_matcher_test;
  import wgm_pkg::*;

  localparam logic [2:0] REG_FIRST_UNUSED = 3'd5;

  typedef enum {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [63:0] value;
    logic [7:0]  ch;
    logic        has;
    logic        fin;
    logic        known;
    logic        want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        character = 8'h00;
  logic              has_character = 1'b0;
  logic              last = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              matched;

  // tag carried alongside the item in flight: typed expectation, if any
  logic tag_known = 1'b0;
  logic tag_want  = 1'b0;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  int   errors     = 0;
  int   sent_items = 0;
  logic match_q[$];
  stim_row_t dir_rows[$];

  // predictor state
  logic [63:0] pat_word[4];
  logic [5:0]  pat_len;
  logic [32:0] live_set;

  wildcard_glob_matcher dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .character(character), .has_character(has_character), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .matched(matched)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int used_len();
    return (pat_len > 6'd32) ? 32 : int'(pat_len);
  endfunction

  function automatic logic [7:0] pat_byte(int i);
    return pat_word[i >> 3][(i & 7) * 8 +: 8];
  endfunction

  function automatic logic [32:0] close_over_stars(logic [32:0] s);
    int n;
    n = used_len();
    for (int i = 0; i < n; i++)
      if (s[i] && pat_byte(i) == CHAR_STAR) s[i+1] = 1'b1;
    return s;
  endfunction

  function automatic void model_write(logic [2:0] idx, logic [63:0] v);
    if (idx <= REG_WORD3) pat_word[idx[1:0]] = v;
    else if (idx == REG_LENGTH) pat_len = v[5:0];
    else return;
    live_set = close_over_stars(33'd1);
  endfunction

  function automatic void model_step(logic [7:0] c, logic h, logic l,
                                     output logic emit, output logic m);
    logic [32:0] nxt;
    logic [7:0]  p;
    int          n;
    n = used_len();
    emit = 1'b0;
    m = 1'b0;
    if (h) begin
      nxt = '0;
      for (int i = 0; i < n; i++) begin
        if (live_set[i]) begin
          p = pat_byte(i);
          if (p == CHAR_STAR) nxt[i] = 1'b1;
          else if (p == CHAR_QUESTION || p == c) nxt[i+1] = 1'b1;
        end
      end
      live_set = close_over_stars(nxt);
    end
    if (l) begin
      emit = 1'b1;
      m = live_set[n];
      live_set = close_over_stars(33'd1);
    end
  endfunction

  function automatic stim_row_t cfg_row(logic [2:0] idx, logic [63:0] v);
    stim_row_t r;
    r = '{ROW_CFG, idx, v, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0};
    return r;
  endfunction

  function automatic stim_row_t item_row(logic [7:0] c, logic h, logic l,
                                         logic known, logic want);
    stim_row_t r;
    r = '{ROW_ITEM, 3'd0, 64'd0, c, h, l, known, want};
    return r;
  endfunction

  function automatic void add_row(stim_row_t r);
    dir_rows = {dir_rows, r};
  endfunction

  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'h61 + 8'($urandom_range(2));
    if (r < 80) return $urandom_range(1) ? CHAR_STAR : CHAR_QUESTION;
    return 8'($urandom_range(255));
  endfunction

  task automatic note_mismatch(string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      out_ready <= 1'b0;
      hold_left <= 400;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // scoreboard: retire results first, then predict for the accepted item
  always @(posedge clk) begin
    logic emit;
    logic m;
    logic want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (match_q.size() == 0) begin
          note_mismatch("result with nothing pending");
        end else begin
          want = match_q.pop_front();
          if (matched !== want)
            note_mismatch($sformatf("matched %b, want %b", matched, want));
        end
      end
      if (in_valid && in_ready) begin
        model_step(character, has_character, last, emit, m);
        if (emit) match_q = {match_q, (tag_known ? tag_want : m)};
      end
    end
  end

  task automatic send_item(logic [7:0] c, logic h, logic l, logic known, logic want);
    character     <= c;
    has_character <= h;
    last          <= l;
    tag_known     <= known;
    tag_want      <= want;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (match_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model_write(idx, v);
    @(posedge clk);
  endtask

  task automatic new_pattern();
    logic [63:0] w[4];
    logic [7:0]  b;
    int          r;
    int          len;
    r = $urandom_range(99);
    if (r < 85) len = $urandom_range(0, 8);
    else if (r < 95) len = $urandom_range(9, 32);
    else len = $urandom_range(33, 63);
    for (int i = 0; i < 32; i++) begin
      r = $urandom_range(99);
      if (r < 35) b = CHAR_STAR;
      else if (r < 50) b = CHAR_QUESTION;
      else if (r < 90) b = 8'h61 + 8'($urandom_range(2));
      else b = 8'($urandom_range(255));
      w[i >> 3][(i & 7) * 8 +: 8] = b;
    end
    for (int k = 0; k < 4; k++) reg_write(REG_WORD0 + 3'(k), w[k]);
    reg_write(REG_LENGTH, 64'(len) | (64'($urandom) << 6));
    if ($urandom_range(99) < 20)
      reg_write(REG_FIRST_UNUSED + 3'($urandom_range(2)), {$urandom, $urandom});
  endtask

  task automatic send_string();
    logic [7:0] str[$];
    logic [7:0] p;
    logic       tail_empty;
    int         n;
    n = used_len();
    for (int i = 0; i < n; i++) begin
      p = pat_byte(i);
      if (p == CHAR_STAR) repeat ($urandom_range(0, 3)) str = {str, rand_char()};
      else if (p == CHAR_QUESTION) str = {str, rand_char()};
      else str = {str, p};
    end
    if ($urandom_range(99) < 40) begin
      case ($urandom_range(2))
        0: if (str.size() > 0) str[$urandom_range(str.size() - 1)] = rand_char();
        1: if (str.size() > 0) str.delete($urandom_range(str.size() - 1));
        default: str = {str, rand_char()};
      endcase
    end
    tail_empty = (str.size() == 0) || ($urandom_range(99) < 15);
    foreach (str[i]) begin
      if ($urandom_range(99) < 8) send_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, 1'b0);
      send_item(str[i], 1'b1, (i == str.size() - 1) && !tail_empty, 1'b0, 1'b0);
    end
    if (tail_empty) send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, 1'b0);
  endtask

  initial begin
    int first;
    int spins;
    int strings;
    for (int k = 0; k < 4; k++) pat_word[k] = '0;
    pat_len  = '0;
    live_set = close_over_stars(33'd1);

    // after reset: empty pattern
    add_row(item_row(8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
    add_row(item_row(8'h61, 1'b1, 1'b1, 1'b1, 1'b0));
    // pattern "a*b?"
    add_row(cfg_row(REG_WORD0, 64'h0000_0000_3F62_2A61));
    add_row(cfg_row(REG_LENGTH, 64'd4));
    add_row(item_row(8'h61, 1'b1, 1'b0, 1'b0, 1'b0));
    add_row(item_row(8'h62, 1'b1, 1'b0, 1'b0, 1'b0));
    add_row(item_row(8'h78, 1'b1, 1'b1, 1'b0, 1'b0));
    add_row(item_row(8'h61, 1'b1, 1'b0, 1'b0, 1'b0));
    add_row(item_row(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0));
    add_row(item_row(8'h62, 1'b1, 1'b0, 1'b0, 1'b0));
    add_row(item_row(8'h63, 1'b1, 1'b1, 1'b0, 1'b0));
    add_row(item_row(8'h61, 1'b1, 1'b0, 1'b0, 1'b0));
    add_row(item_row(8'h62, 1'b1, 1'b1, 1'b0, 1'b0));
    add_row(item_row(8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
    // all stars, length above the maximum
    for (int k = 0; k < 4; k++)
      add_row(cfg_row(REG_WORD0 + 3'(k), 64'h2A2A_2A2A_2A2A_2A2A));
    add_row(cfg_row(REG_LENGTH, 64'd63));
    add_row(item_row(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));
    add_row(item_row(8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
    add_row(item_row(8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
    // zero pattern byte and all-ones byte; unused register index
    add_row(cfg_row(REG_WORD0, 64'h0000_0000_0000_FF00));
    add_row(cfg_row(REG_WORD1, 64'd0));
    add_row(cfg_row(REG_WORD2, 64'd0));
    add_row(cfg_row(REG_WORD3, 64'hFFFF_FFFF_FFFF_FFFF));
    add_row(cfg_row(REG_LENGTH, 64'd2));
    add_row(cfg_row(REG_FIRST_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF));
    add_row(item_row(8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
    add_row(item_row(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0));
    add_row(item_row(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0));
    add_row(item_row(8'h00, 1'b1, 1'b1, 1'b0, 1'b0));
    add_row(cfg_row(REG_LENGTH, 64'd0));
    add_row(item_row(8'h00, 1'b0, 1'b1, 1'b1, 1'b1));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_idle();
        reg_write(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        send_item(dir_rows[i].ch, dir_rows[i].has, dir_rows[i].fin,
                  dir_rows[i].known, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 52; end
        default: begin send_idle_pct = 29; recv_stall_pct <= 29; end
      endcase
      first = sent_items;
      while (sent_items - first < 155) begin
        wait_idle();
        new_pattern();
        if (ph == 0 && sent_items == first) hold_req <= ~hold_req;
        strings = $urandom_range(8, 14);
        for (int s = 0; s < strings && sent_items - first < 155; s++) send_string();
      end
    end

    in_valid <= 1'b0;
    spins = 0;
    while (match_q.size() != 0 && spins < 20000) begin
      @(posedge clk);
      spins++;
    end
    repeat (10) @(posedge clk);
    if (match_q.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", match_q.size()));
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/wgm_pkg.sv
rtl/core/wgm_cfg.sv
rtl/core/wgm_step.sv
rtl/core/wildcard_glob_matcher.sv
rtl/core/wgm_checker.sv
tb/wildcard_glob_matcher_test.sv
